FILE: hdl/tebp_pkg.sv
`timescale 1ns / 1ps

package tebp_pkg;

    localparam int SEQ_COUNT_W   = 14;
    localparam int LIMIT_RESET   = 8192;
    localparam int LIMIT_CEILING = 16382;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] BYTE_BEL       = 8'h07;
    localparam logic [7:0] BYTE_BS        = 8'h08;
    localparam logic [7:0] BYTE_HT        = 8'h09;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_VT        = 8'h0B;
    localparam logic [7:0] BYTE_FF        = 8'h0C;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_CAN       = 8'h18;
    localparam logic [7:0] BYTE_SUB       = 8'h1A;
    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_DEL       = 8'h7F;
    localparam logic [7:0] BYTE_HIGH      = 8'h80;
    localparam logic [7:0] BYTE_CONT_MAX  = 8'hBF;
    localparam logic [7:0] BYTE_FINAL_MIN = 8'h40;
    localparam logic [7:0] BYTE_FINAL_MAX = 8'h7E;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
    localparam logic [7:0] BYTE_RBRACKET  = 8'h5D;
    localparam logic [7:0] BYTE_BSLASH    = 8'h5C;

    localparam logic [31:0] REPL_GLYPH     = 32'h00EF_BFBD;
    localparam logic [2:0]  REPL_GLYPH_LEN = 3'd3;

    typedef enum logic [5:0] {
        MODE_GROUND  = 6'b000001,
        MODE_ESC     = 6'b000010,
        MODE_CSI     = 6'b000100,
        MODE_OSC     = 6'b001000,
        MODE_STR     = 6'b010000,
        MODE_CHARSET = 6'b100000
    } mode_t;

    typedef enum logic [4:0] {
        ACT_ASCII       = 5'd0,
        ACT_GLYPH       = 5'd1,
        ACT_REPLACEMENT = 5'd2,
        ACT_CR          = 5'd3,
        ACT_LF          = 5'd4,
        ACT_INDEX       = 5'd5,
        ACT_NEXTLINE    = 5'd6,
        ACT_BS          = 5'd7,
        ACT_TAB         = 5'd8,
        ACT_SAVE        = 5'd9,
        ACT_RESTORE     = 5'd10,
        ACT_TABSET      = 5'd11,
        ACT_IDENTIFY    = 5'd12,
        ACT_REVINDEX    = 5'd13,
        ACT_CSIBYTE     = 5'd14,
        ACT_CSIFINAL    = 5'd15,
        ACT_OSCBYTE     = 5'd16,
        ACT_OSCDISPATCH = 5'd17,
        ACT_ABANDON     = 5'd18,
        ACT_CANCEL      = 5'd19
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  data_byte;
        logic [31:0] glyph_bytes;
        logic [2:0]  glyph_length;
        logic        last_action;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic                   act_valid;
        action_t                act;
    } motion_t;

    typedef struct packed {
        mode_t                  mode;
        logic [SEQ_COUNT_W-1:0] count;
        logic                   act_valid;
        action_t                act;
    } esc_step_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b < BYTE_HIGH)
            len = 3'd1;
        else if (b >= 8'hC2 && b <= 8'hDF)
            len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            len = 3'd4;
        return len;
    endfunction

    function automatic motion_t c0_motion(input logic [7:0] b);
        motion_t m;
        m.act_valid = 1'b1;
        m.act       = ACT_CR;
        case (b)
            BYTE_CR: m.act = ACT_CR;
            BYTE_LF: m.act = ACT_LF;
            BYTE_VT: m.act = ACT_INDEX;
            BYTE_FF: m.act = ACT_INDEX;
            BYTE_BS: m.act = ACT_BS;
            BYTE_HT: m.act = ACT_TAB;
            default: m.act_valid = 1'b0;
        endcase
        return m;
    endfunction

    function automatic esc_step_t after_escape(input logic [7:0] b);
        esc_step_t s;
        s.mode      = MODE_GROUND;
        s.count     = '0;
        s.act_valid = 1'b1;
        s.act       = ACT_SAVE;
        case (b)
            BYTE_LBRACKET:
            begin
                s.mode      = MODE_CSI;
                s.count     = SEQ_COUNT_W'(1);
                s.act_valid = 1'b0;
            end
            BYTE_RBRACKET:
            begin
                s.mode      = MODE_OSC;
                s.count     = SEQ_COUNT_W'(1);
                s.act_valid = 1'b0;
            end
            8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F:
            begin
                s.mode      = MODE_CHARSET;
                s.count     = SEQ_COUNT_W'(1);
                s.act_valid = 1'b0;
            end
            8'h50, 8'h58, 8'h5E, 8'h5F:
            begin
                s.mode      = MODE_STR;
                s.act_valid = 1'b0;
            end
            8'h37: s.act = ACT_SAVE;
            8'h38: s.act = ACT_RESTORE;
            8'h48: s.act = ACT_TABSET;
            8'h5A: s.act = ACT_IDENTIFY;
            8'h44: s.act = ACT_INDEX;
            8'h45: s.act = ACT_NEXTLINE;
            8'h4D: s.act = ACT_REVINDEX;
            default: s.act_valid = 1'b0;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/terminal_escape_byte_parser.sv
`timescale 1ns / 1ps

// Terminal output byte classifier.
// s_axis carries one raw byte per beat (tdata[7:0]). m_axis carries the
// classified actions: ascii, UTF-8 glyph, replacement, C0 motions, ESC
// commands, streamed CSI/OSC bytes with their dispatch, abandon and cancel.
// Each input byte yields zero, one or two output beats; tlast marks the final
// beat caused by a byte, and a byte that yields nothing gives no beat.
// Each action is queued when its byte is accepted and leaves m_axis in order.
// Throughput: one byte per cycle while s_axis_tready is high; the parse state
// is registered and feeds a four-beat result queue. Sustained output is one
// beat per cycle while m_axis_tready is high, so bytes that expand to two
// actions slow the input to match. When the receiver stalls, the queue fills
// and s_axis_tready drops once fewer than two free slots remain; none is lost.
// cfg_wr_en/cfg_wr_data set the sequence length limit (clamped to
// LENGTH_LIMIT_MAX and 16382); write it only while the block is idle.
// Reset returns to ground mode, drops held UTF-8 bytes, empties the queue
// and sets the limit to 8192 (clamped the same way).
module terminal_escape_byte_parser #(
    parameter int LENGTH_LIMIT_MAX = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] action, [12:5] data_byte, [44:13] glyph_bytes, [47:45] glyph_length
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_action
    input  logic        cfg_wr_en,
    input  logic [13:0] cfg_wr_data
);
    import tebp_pkg::*;

    localparam int LIMIT_CAP = (LENGTH_LIMIT_MAX < LIMIT_CEILING) ?
                               LENGTH_LIMIT_MAX : LIMIT_CEILING;
    localparam int LIMIT_INIT = (LIMIT_RESET < LIMIT_CAP) ? LIMIT_RESET : LIMIT_CAP;
    localparam logic [SEQ_COUNT_W-1:0] LIMIT_CAP_W  = SEQ_COUNT_W'(LIMIT_CAP);
    localparam logic [SEQ_COUNT_W-1:0] LIMIT_INIT_W = SEQ_COUNT_W'(LIMIT_INIT);

    logic [SEQ_COUNT_W-1:0] limit_reg, limit_next;
    logic                   in_accept;
    push_t                  push;
    result_t                out_r;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign limit_next = (cfg_wr_data > LIMIT_CAP_W) ? LIMIT_CAP_W : cfg_wr_data;

    // hold the clamped limit so the compare path sees a ready value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_INIT_W;
        else if (cfg_wr_en)
            limit_reg <= limit_next;
    end

    tebp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .limit     (limit_reg),
        .push      (push)
    );

    tebp_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_ready  (s_axis_tready),
        .out_data  (out_r),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_r.glyph_length, out_r.glyph_bytes, out_r.data_byte,
                           out_r.action};
    assign m_axis_tlast = out_r.last_action;

endmodule

FILE: hdl/tebp_decode.sv
`timescale 1ns / 1ps

module tebp_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_accept,
    input  logic [7:0]                      in_byte,
    input  logic [tebp_pkg::SEQ_COUNT_W-1:0] limit,
    output tebp_pkg::push_t                 push
);
    import tebp_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic                   pend_reg, pend_next;
    logic [23:0]            held_reg, held_next;
    logic [1:0]             hcnt_reg, hcnt_next;
    logic [SEQ_COUNT_W-1:0] cnt_reg, cnt_next;

    logic                   pre_v;
    action_t                pre_act;
    logic                   main_v;
    action_t                main_act;
    logic [7:0]             main_data;
    logic [31:0]            main_glyph;
    logic [2:0]             main_glen;

    logic [1:0]             cur_cnt;
    logic [7:0]             first_byte;
    logic [2:0]             first_len;
    logic [2:0]             new_len;
    logic [SEQ_COUNT_W-1:0] cnt_inc;
    esc_step_t              esc;
    motion_t                mot;
    logic                   is_cancel;
    logic                   is_osc;
    result_t                pre_r, main_r;

    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        held_next  = held_reg;
        hcnt_next  = hcnt_reg;
        cnt_next   = cnt_reg;
        pre_v      = 1'b0;
        pre_act    = ACT_REPLACEMENT;
        main_v     = 1'b0;
        main_act   = ACT_ASCII;
        main_data  = '0;
        main_glyph = '0;
        main_glen  = '0;
        cur_cnt    = hcnt_reg;
        first_byte = held_reg[7:0];
        first_len  = '0;
        new_len    = {1'b0, hcnt_reg} + 3'd1;
        cnt_inc    = cnt_reg + SEQ_COUNT_W'(1);
        esc        = after_escape(in_byte);
        mot        = c0_motion(in_byte);
        is_cancel  = (in_byte == BYTE_CAN) || (in_byte == BYTE_SUB);
        is_osc     = (mode_reg == MODE_OSC);

        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = esc.mode;
                cnt_next  = esc.count;
                pend_next = 1'b0;
                main_v    = esc.act_valid;
                main_act  = esc.act;
            end
            MODE_CSI:
            begin
                if (in_byte == BYTE_ESC)
                begin
                    main_v    = 1'b1;
                    main_act  = ACT_CANCEL;
                    mode_next = MODE_ESC;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (is_cancel)
                begin
                    main_v    = 1'b1;
                    main_act  = ACT_CANCEL;
                    mode_next = MODE_GROUND;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (in_byte < BYTE_SPACE)
                begin
                    main_v   = mot.act_valid;
                    main_act = mot.act;
                end
                else if (in_byte >= BYTE_FINAL_MIN && in_byte <= BYTE_FINAL_MAX)
                begin
                    main_v    = 1'b1;
                    main_act  = ACT_CSIFINAL;
                    main_data = in_byte;
                    mode_next = MODE_GROUND;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (cnt_inc > limit)
                begin
                    main_v    = 1'b1;
                    main_act  = ACT_ABANDON;
                    mode_next = MODE_GROUND;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else
                begin
                    cnt_next  = cnt_inc;
                    main_v    = 1'b1;
                    main_act  = ACT_CSIBYTE;
                    main_data = in_byte;
                end
            end
            MODE_OSC, MODE_STR:
            begin
                if (is_cancel)
                begin
                    main_v    = 1'b1;
                    main_act  = ACT_CANCEL;
                    mode_next = MODE_GROUND;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (pend_reg)
                begin
                    // terminator ESC seen: dispatch (OSC only), then treat this beat as the ESC final
                    pend_next = 1'b0;
                    pre_v     = is_osc;
                    pre_act   = ACT_OSCDISPATCH;
                    if (in_byte == BYTE_BSLASH)
                    begin
                        mode_next = MODE_GROUND;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        mode_next = esc.mode;
                        cnt_next  = esc.count;
                        main_v    = esc.act_valid;
                        main_act  = esc.act;
                    end
                end
                else if (in_byte == BYTE_BEL)
                begin
                    main_v    = is_osc;
                    main_act  = ACT_OSCDISPATCH;
                    mode_next = MODE_GROUND;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (in_byte == BYTE_ESC)
                begin
                    pend_next = 1'b1;
                end
                else if (cnt_reg > limit)
                begin
                    main_v    = 1'b1;
                    main_act  = ACT_ABANDON;
                    mode_next = MODE_GROUND;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else
                begin
                    cnt_next  = cnt_inc;
                    main_v    = is_osc;
                    main_act  = ACT_OSCBYTE;
                    main_data = in_byte;
                end
            end
            MODE_CHARSET:
            begin
                pend_next = 1'b0;
                cnt_next  = '0;
                if (in_byte == BYTE_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    main_v    = is_cancel;
                    main_act  = ACT_CANCEL;
                    mode_next = MODE_GROUND;
                end
            end
            default:
            begin
                mode_next = MODE_GROUND;
                if (in_byte == BYTE_ESC)
                begin
                    pre_v     = (hcnt_reg != 2'd0);
                    held_next = '0;
                    hcnt_next = '0;
                    mode_next = MODE_ESC;
                    pend_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (in_byte >= BYTE_HIGH)
                begin
                    // broken sequence: replace held bytes, retry this byte as a lead
                    if (hcnt_reg != 2'd0 && in_byte > BYTE_CONT_MAX)
                    begin
                        pre_v     = 1'b1;
                        cur_cnt   = '0;
                        held_next = '0;
                        hcnt_next = '0;
                    end
                    if (cur_cnt == 2'd0)
                    begin
                        if (lead_len(in_byte) == 3'd0)
                        begin
                            main_v     = 1'b1;
                            main_act   = ACT_REPLACEMENT;
                            main_glyph = REPL_GLYPH;
                            main_glen  = REPL_GLYPH_LEN;
                        end
                        else
                        begin
                            held_next = {16'h0000, in_byte};
                            hcnt_next = 2'd1;
                        end
                    end
                    else
                    begin
                        case (cur_cnt)
                            2'd1:    first_byte = held_reg[7:0];
                            2'd2:    first_byte = held_reg[15:8];
                            2'd3:    first_byte = held_reg[23:16];
                            default: first_byte = held_reg[7:0];
                        endcase
                        first_len = lead_len(first_byte);
                        if (new_len >= first_len)
                        begin
                            main_v     = 1'b1;
                            main_act   = ACT_GLYPH;
                            main_glyph = {held_reg, in_byte};
                            main_glen  = new_len;
                            held_next  = '0;
                            hcnt_next  = '0;
                        end
                        else
                        begin
                            held_next = {held_reg[15:0], in_byte};
                            hcnt_next = new_len[1:0];
                        end
                    end
                end
                else
                begin
                    pre_v     = (hcnt_reg != 2'd0);
                    held_next = '0;
                    hcnt_next = '0;
                    if (in_byte < BYTE_SPACE)
                    begin
                        main_v   = mot.act_valid;
                        main_act = mot.act;
                    end
                    else if (in_byte != BYTE_DEL)
                    begin
                        main_v    = 1'b1;
                        main_act  = ACT_ASCII;
                        main_data = in_byte;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        pre_r.action       = pre_act;
        pre_r.data_byte    = '0;
        pre_r.glyph_bytes  = (pre_act == ACT_REPLACEMENT) ? REPL_GLYPH : '0;
        pre_r.glyph_length = (pre_act == ACT_REPLACEMENT) ? REPL_GLYPH_LEN : '0;
        pre_r.last_action  = 1'b0;

        main_r.action       = main_act;
        main_r.data_byte    = main_data;
        main_r.glyph_bytes  = main_glyph;
        main_r.glyph_length = main_glen;
        main_r.last_action  = 1'b1;

        push.n      = in_accept ? ({1'b0, pre_v} + {1'b0, main_v}) : 2'd0;
        push.first  = pre_v ? pre_r : main_r;
        push.second = main_r;
        push.first.last_action = !(pre_v && main_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_GROUND;
            pend_reg <= 1'b0;
            held_reg <= '0;
            hcnt_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (in_accept)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            held_reg <= held_next;
            hcnt_reg <= hcnt_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_held_only_in_ground: assert property (@(posedge clk) disable iff (!rst_n)
        (hcnt_reg != 2'd0) |-> (mode_reg == MODE_GROUND))
        else $error("utf-8 bytes held outside ground mode");

    a_pend_only_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (mode_reg == MODE_OSC || mode_reg == MODE_STR))
        else $error("pending ESC outside OSC or string payload");

    a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(mode_reg))
        else $error("escape mode register is not one-hot");

endmodule

FILE: hdl/tebp_result_queue.sv
`timescale 1ns / 1ps

module tebp_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tebp_pkg::push_t   push,
    output logic              in_ready,
    output tebp_pkg::result_t out_data,
    output logic              out_valid,
    input  logic              out_ready
);
    import tebp_pkg::*;

    result_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wptr_second;
    logic                pop;

    assign pop         = out_valid && out_ready;
    assign out_valid   = (count_reg != '0);
    assign out_data    = q_reg[rptr_reg];
    assign in_ready    = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign wptr_second = wptr_reg + QPTR_W'(1);

    always_comb
    begin
        wptr_next  = wptr_reg + QPTR_W'(push.n);
        rptr_next  = rptr_reg + QPTR_W'(pop);
        count_next = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            q_reg[wptr_reg] <= push.first;
        if (push.n == 2'd2)
            q_reg[wptr_second] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue holds more beats than its depth");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> in_ready)
        else $error("results pushed while queue lacks room for two beats");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.n == 2'd0) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("queue fill did not drop after a lone pop");

endmodule
